[rtl/assert_macros.svh]
// Assertion macros shared by the RTL; clk and rst are taken from the enclosing scope.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property must hold at every edge outside reset
`define BSP_CHECK(lbl, prop) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) \
    else $error("bsp check failed");

// expression must never be true outside reset
`define BSP_NEVER(lbl, expr) \
  lbl: assert property (@(posedge clk) disable iff (rst) !(expr)) \
    else $error("bsp forbidden condition seen");

`endif

[rtl/bsp_pkg.sv]
// Shared constants and types for the bounding sphere pair block.
package bsp_pkg;

  localparam int unsigned COORD_BITS_DEF = 32;
  localparam int unsigned Q_DEPTH        = 4;
  localparam int unsigned Q_AW           = $clog2(Q_DEPTH);
  localparam int unsigned Q_CW           = $clog2(Q_DEPTH + 1);

  typedef struct packed {
    logic full;
    logic empty;
  } bsp_q_stat_t;

endpackage

[rtl/bounding_sphere_pair_ops.sv]
// Bounding sphere pair operations: top level joining front end, queue and back end.
// Usage:
//   Input stream s_t*: one word per sphere pair A, B (centres signed, radii unsigned).
//   Output stream m_t*: one word per pair with the enclosing sphere, the growth
//   radius (distance + rA + rB) / 2 and a strict overlap flag.
//   Throughput: one pair per cycle when the receiver keeps m_tready high.
//   A pair passes the front end, the queue, the square root (one root bit per stage),
//   the scaling registers, the per-axis dividers and the result register to m_tvalid.
//   The front end (3 stages) feeds a 4-word queue; the back end pulls from it.
//   When m_tready is low the back end holds, the queue fills, and only then does
//   s_tready fall; s_tready depends on registered state alone.
//   Reset (rst, synchronous) empties the queue and clears every valid bit; the
//   block takes words in the cycle after reset is released.
//   No configuration and no state across pairs.
module bounding_sphere_pair_ops #(
  parameter int unsigned COORD_BITS = bsp_pkg::COORD_BITS_DEF
) (
  input  logic                                  clk,
  input  logic                                  rst,
  input  logic                                  s_tvalid,
  output logic                                  s_tready,
  // a_x, a_y, a_z, a_radius, b_x, b_y, b_z, b_radius, zero pad
  input  logic [((8*COORD_BITS-2+7)/8)*8-1:0]   s_tdata,
  output logic                                  m_tvalid,
  input  logic                                  m_tready,
  // merged_x, merged_y, merged_z, merged_radius, growth_radius, spheres_overlap, zero pad
  output logic [((5*COORD_BITS-1+7)/8)*8-1:0]   m_tdata
);

`include "assert_macros.svh"

  logic                      push, pop;
  logic [10*COORD_BITS+2:0]  push_data, q_data;
  bsp_pkg::bsp_q_stat_t      q_stat;

  bsp_front #(.COORD_BITS(COORD_BITS)) u_front (
    .clk       (clk),
    .rst       (rst),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .q_stat    (q_stat),
    .push      (push),
    .push_data (push_data)
  );

  bsp_queue #(.COORD_BITS(COORD_BITS)) u_queue (
    .clk    (clk),
    .rst    (rst),
    .push   (push),
    .wdata  (push_data),
    .pop    (pop),
    .rdata  (q_data),
    .q_stat (q_stat)
  );

  bsp_back #(.COORD_BITS(COORD_BITS)) u_back (
    .clk      (clk),
    .rst      (rst),
    .q_stat   (q_stat),
    .q_data   (q_data),
    .pop      (pop),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
  );

  `BSP_CHECK(a_push_room, push |-> !q_stat.full)
  `BSP_CHECK(a_pop_data, pop |-> !q_stat.empty)
  `BSP_NEVER(a_pop_stalled, pop && m_tvalid && !m_tready)

endmodule

[rtl/bsp_front.sv]
// Front end: takes input words, forms axis deltas, squares and the two classifying compares.
module bsp_front #(
  parameter int unsigned COORD_BITS = bsp_pkg::COORD_BITS_DEF
) (
  input  logic                                   clk,
  input  logic                                   rst,
  input  logic                                   s_tvalid,
  output logic                                   s_tready,
  input  logic [((8*COORD_BITS-2+7)/8)*8-1:0]    s_tdata,
  input  bsp_pkg::bsp_q_stat_t                   q_stat,
  output logic                                   push,
  output logic [10*COORD_BITS+2:0]               push_data
);

  localparam int unsigned W = COORD_BITS;

  typedef struct packed {
    logic [2:0][W-1:0] a;
    logic [2:0][W-1:0] b;
    logic [W-2:0]      ra;
    logic [W-2:0]      rb;
    logic [2*W+1:0]    sq;
    logic              contain;
    logic              take_a;
    logic              overlap;
  } ent_t;

  logic en;

  logic              f1v, f2v, f3v;
  logic [2:0][W-1:0] f1_a, f1_b, f2_a, f2_b;
  logic [W-2:0]      f1_ra, f1_rb, f2_ra, f2_rb;
  logic [2:0][W:0]   f1_dmag;
  logic [W-2:0]      f1_rdiff;
  logic [W-1:0]      f1_rsum;
  logic              f1_take_a, f2_take_a;
  logic [2:0][2*W+1:0] f2_sqd;
  logic [2*W-3:0]    f2_rdiff2;
  logic [2*W-1:0]    f2_rsum2;
  ent_t              f3;

  logic [2:0][W-1:0] in_a, in_b;
  logic [W-2:0]      in_ra, in_rb;
  logic [2:0][W:0]   dmag_next;
  logic [2*W+1:0]    sq_next;

  assign en        = !(f3v && q_stat.full);
  assign s_tready  = en;
  assign push      = f3v && !q_stat.full;
  assign push_data = f3;

  always_comb begin
    logic signed [W:0] diff;
    diff = '0;
    for (int i = 0; i < 3; i++) begin
      in_a[i] = s_tdata[i*W +: W];
      in_b[i] = s_tdata[4*W-1 + i*W +: W];
    end
    in_ra = s_tdata[3*W +: W-1];
    in_rb = s_tdata[7*W-1 +: W-1];
    for (int i = 0; i < 3; i++) begin
      diff = $signed({in_b[i][W-1], in_b[i]}) - $signed({in_a[i][W-1], in_a[i]});
      // the difference of two W-bit signed values fits in W+1 bits, so negation gives the exact magnitude
      dmag_next[i] = diff[W] ? -diff : diff;
    end
  end

  assign sq_next = f2_sqd[0] + f2_sqd[1] + f2_sqd[2];

  always_ff @(posedge clk) begin
    if (rst) begin
      f1v <= 1'b0;
      f2v <= 1'b0;
      f3v <= 1'b0;
    end else if (en) begin
      f1v <= s_tvalid;
      f2v <= f1v;
      f3v <= f2v;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      f1_a      <= in_a;
      f1_b      <= in_b;
      f1_ra     <= in_ra;
      f1_rb     <= in_rb;
      f1_dmag   <= dmag_next;
      f1_rdiff  <= (in_ra > in_rb) ? in_ra - in_rb : in_rb - in_ra;
      f1_rsum   <= {1'b0, in_ra} + {1'b0, in_rb};
      f1_take_a <= in_ra > in_rb;

      f2_a      <= f1_a;
      f2_b      <= f1_b;
      f2_ra     <= f1_ra;
      f2_rb     <= f1_rb;
      f2_take_a <= f1_take_a;
      for (int i = 0; i < 3; i++) begin
        f2_sqd[i] <= f1_dmag[i] * f1_dmag[i];
      end
      f2_rdiff2 <= f1_rdiff * f1_rdiff;
      f2_rsum2  <= f1_rsum * f1_rsum;

      f3.a       <= f2_a;
      f3.b       <= f2_b;
      f3.ra      <= f2_ra;
      f3.rb      <= f2_rb;
      f3.sq      <= sq_next;
      f3.contain <= {4'b0, f2_rdiff2} >= sq_next;
      f3.take_a  <= f2_take_a;
      f3.overlap <= sq_next < {2'b0, f2_rsum2};
    end
  end

endmodule

[rtl/bsp_queue.sv]
// Short word queue between the front and back ends.
module bsp_queue #(
  parameter int unsigned COORD_BITS = bsp_pkg::COORD_BITS_DEF
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         push,
  input  logic [10*COORD_BITS+2:0]     wdata,
  input  logic                         pop,
  output logic [10*COORD_BITS+2:0]     rdata,
  output bsp_pkg::bsp_q_stat_t         q_stat
);

  logic [10*COORD_BITS+2:0]    mem [0:bsp_pkg::Q_DEPTH-1];
  logic [bsp_pkg::Q_AW-1:0]    wr_ptr, rd_ptr;
  logic [bsp_pkg::Q_CW-1:0]    count, count_next;

  assign rdata        = mem[rd_ptr];
  assign q_stat.full  = count == bsp_pkg::Q_CW'(bsp_pkg::Q_DEPTH);
  assign q_stat.empty = count == '0;

  always_comb begin
    unique case ({push, pop})
      2'b10:   count_next = count + 1'b1;
      2'b01:   count_next = count - 1'b1;
      default: count_next = count;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) wr_ptr <= wr_ptr + 1'b1;
      if (pop) rd_ptr <= rd_ptr + 1'b1;
      count <= count_next;
    end
  end

  always_ff @(posedge clk) begin
    if (push) mem[wr_ptr] <= wdata;
  end

endmodule

[rtl/bsp_div.sv]
// Pipelined restoring divider, one quotient bit per stage.
module bsp_div #(
  parameter int unsigned COORD_BITS = bsp_pkg::COORD_BITS_DEF
) (
  input  logic                      clk,
  input  logic                      en,
  input  logic [2*COORD_BITS+1:0]   num,
  input  logic [COORD_BITS:0]       den,
  output logic [COORD_BITS:0]       quo
);

  localparam int unsigned W = COORD_BITS;
  localparam int unsigned Q = W + 1;

  logic [W:0] rem [1:Q];
  logic [W:0] qq  [1:Q];
  logic [W:0] nm  [1:Q];
  logic [W:0] dn  [1:Q];

  for (genvar j = 1; j <= Q; j++) begin : g_stage
    logic [W:0]   prem, pnum, pden, pq;
    logic [W+1:0] r;
    logic         ge;
    if (j == 1) begin : g_first
      // high half seeds the remainder; quotient is known to fit in Q bits
      assign prem = num[2*W+1:W+1];
      assign pnum = num[W:0];
      assign pden = den;
      assign pq   = '0;
    end else begin : g_next
      assign prem = rem[j-1];
      assign pnum = nm[j-1];
      assign pden = dn[j-1];
      assign pq   = qq[j-1];
    end
    assign r  = {prem, pnum[W+1-j]};
    assign ge = r >= {1'b0, pden};
    always_ff @(posedge clk) begin
      if (en) begin
        rem[j] <= ge ? (W+1)'(r - {1'b0, pden}) : r[W:0];
        qq[j]  <= {pq[W-1:0], ge};
        nm[j]  <= pnum;
        dn[j]  <= pden;
      end
    end
  end

  assign quo = qq[Q];

endmodule

[rtl/bsp_back.sv]
// Back end: square root, radius and offset scaling, per-axis division and the result register.
module bsp_back #(
  parameter int unsigned COORD_BITS = bsp_pkg::COORD_BITS_DEF
) (
  input  logic                                  clk,
  input  logic                                  rst,
  input  bsp_pkg::bsp_q_stat_t                  q_stat,
  input  logic [10*COORD_BITS+2:0]              q_data,
  output logic                                  pop,
  output logic                                  m_tvalid,
  input  logic                                  m_tready,
  output logic [((5*COORD_BITS-1+7)/8)*8-1:0]   m_tdata
);

  localparam int unsigned W  = COORD_BITS;
  localparam int unsigned NS = W + 1;

  typedef struct packed {
    logic [2:0][W-1:0] a;
    logic [2:0][W-1:0] b;
    logic [W-2:0]      ra;
    logic [W-2:0]      rb;
    logic [2*W+1:0]    sq;
    logic              contain;
    logic              take_a;
    logic              overlap;
  } ent_t;

  typedef struct packed {
    ent_t       e;
    logic [W:0] sum;
    logic [W:0] span;
    logic [2:0] dneg;
  } side_t;

  logic en;

  logic       sv    [0:NS];
  ent_t       se    [0:NS];
  logic [W+3:0] srem [1:NS];
  logic [W:0] sroot [1:NS];

  logic            kv;
  side_t           ks;
  logic [2:0][W:0] kdmag;
  logic [W:0]      kk;

  logic                mv;
  side_t               ms;
  logic [2:0][2*W+1:0] mprod;

  logic            dv [1:NS];
  side_t           ds [1:NS];
  logic [2:0][W:0] quo;

  assign en  = !m_tvalid || m_tready;
  assign pop = en && !q_stat.empty;

  always_ff @(posedge clk) begin
    if (rst) sv[0] <= 1'b0;
    else if (en) sv[0] <= !q_stat.empty;
  end

  always_ff @(posedge clk) begin
    if (en) se[0] <= q_data;
  end

  // square root, two radicand bits per stage
  for (genvar j = 1; j <= NS; j++) begin : g_sqrt
    logic [W+3:0] prem, r2, trial;
    logic [W:0]   proot;
    logic         ge;
    if (j == 1) begin : g_first
      assign prem  = '0;
      assign proot = '0;
    end else begin : g_next
      assign prem  = srem[j-1];
      assign proot = sroot[j-1];
    end
    assign r2    = {prem[W+1:0], se[j-1].sq[2*W+3-2*j -: 2]};
    assign trial = {1'b0, proot, 2'b01};
    assign ge    = r2 >= trial;
    always_ff @(posedge clk) begin
      if (rst) sv[j] <= 1'b0;
      else if (en) sv[j] <= sv[j-1];
    end
    always_ff @(posedge clk) begin
      if (en) begin
        se[j]    <= se[j-1];
        srem[j]  <= ge ? r2 - trial : r2;
        sroot[j] <= {proot[W-1:0], ge};
      end
    end
  end

  // growth radius and the move factor
  logic [W+1:0]      sum_full;
  logic [W:0]        sum_k;
  logic [2:0][W:0]   dmag_k;
  logic [2:0]        dneg_k;

  assign sum_full = {1'b0, sroot[NS]} + {3'b0, se[NS].ra} + {3'b0, se[NS].rb};
  assign sum_k    = sum_full[W+1:1];

  always_comb begin
    logic signed [W:0] diff;
    diff = '0;
    for (int i = 0; i < 3; i++) begin
      diff = $signed({se[NS].b[i][W-1], se[NS].b[i]})
           - $signed({se[NS].a[i][W-1], se[NS].a[i]});
      dneg_k[i] = diff[W];
      dmag_k[i] = diff[W] ? -diff : diff;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      kv <= 1'b0;
      mv <= 1'b0;
    end else if (en) begin
      kv <= sv[NS];
      mv <= kv;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      ks.e    <= se[NS];
      ks.sum  <= sum_k;
      ks.span <= sroot[NS];
      ks.dneg <= dneg_k;
      kdmag   <= dmag_k;
      kk      <= (sum_k >= {2'b0, se[NS].ra}) ? sum_k - {2'b0, se[NS].ra} : '0;

      ms <= ks;
      for (int i = 0; i < 3; i++) begin
        mprod[i] <= kdmag[i] * kk;
      end
    end
  end

  for (genvar i = 0; i < 3; i++) begin : g_axis
    bsp_div #(.COORD_BITS(COORD_BITS)) u_div (
      .clk (clk),
      .en  (en),
      .num (mprod[i]),
      .den (ms.span),
      .quo (quo[i])
    );
  end

  for (genvar j = 1; j <= NS; j++) begin : g_side
    logic  pv;
    side_t ps;
    if (j == 1) begin : g_first
      assign pv = mv;
      assign ps = ms;
    end else begin : g_next
      assign pv = dv[j-1];
      assign ps = ds[j-1];
    end
    always_ff @(posedge clk) begin
      if (rst) dv[j] <= 1'b0;
      else if (en) dv[j] <= pv;
    end
    always_ff @(posedge clk) begin
      if (en) ds[j] <= ps;
    end
  end

  // result assembly
  side_t                            fs;
  logic [2:0][W-1:0]                cen;
  logic [W-2:0]                     grow, mrad;
  logic [((5*COORD_BITS-1+7)/8)*8-1:0] tdata_next;

  assign fs = ds[NS];

  always_comb begin
    logic [W:0] a_ext, moved;
    a_ext = '0;
    moved = '0;
    grow  = (fs.sum[W:W-1] != 2'b00) ? '1 : fs.sum[W-2:0];
    for (int i = 0; i < 3; i++) begin
      a_ext = {fs.e.a[i][W-1], fs.e.a[i]};
      moved = fs.dneg[i] ? a_ext - quo[i] : a_ext + quo[i];
      if (fs.e.contain) cen[i] = fs.e.take_a ? fs.e.a[i] : fs.e.b[i];
      else if (fs.span == '0) cen[i] = fs.e.a[i];
      else cen[i] = moved[W-1:0];
    end
    if (fs.e.contain) mrad = fs.e.take_a ? fs.e.ra : fs.e.rb;
    else mrad = grow;
    tdata_next = '0;
    tdata_next[5*W-2:0] = {fs.e.overlap, grow, mrad, cen[2], cen[1], cen[0]};
  end

  always_ff @(posedge clk) begin
    if (rst) m_tvalid <= 1'b0;
    else if (en) m_tvalid <= dv[NS];
  end

  always_ff @(posedge clk) begin
    if (en) m_tdata <= tdata_next;
  end

endmodule
